>>> hw/rtl/hisa_pkg.sv
// ============================================================================
// hisa_pkg
// Shared types and constants for the histogram intersection score
// accumulator: beat layouts, command and register codes, queue job format.
// ============================================================================
package hisa_pkg;

    // Default sizes, handed to the top level parameters
    localparam int unsigned ENTRIES_DEF    = 4096;
    localparam int unsigned CLUSTERS_DEF   = 65536;
    localparam int unsigned SCORE_BITS_DEF = 32;

    // Command codes of the input beat
    localparam logic [1:0] CMD_ACC  = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // Config register indexes
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ASYM = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FG   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BG   = 2'd2;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [15:0] GAIN_RESET = 16'd16384;   // 1.0 in 2.14

    // Gain scaling: (w * gain + half) >> 14, fits in 18 bits
    localparam int unsigned PROD_BITS  = 32;
    localparam int unsigned GAIN_FRAC  = 14;
    localparam logic [PROD_BITS-1:0] ROUND_HALF = 32'd8192;
    localparam int unsigned INC_BITS   = 18;

    localparam int unsigned OUT_BITS   = 32;
    localparam int unsigned QDEPTH     = 4;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] word_id;
        logic [11:0] entry_id;
        logic [15:0] qry_weight;
        logic [15:0] entry_weight;
        logic        foreground;
        logic        stop_value;
    } t_cmd;

    typedef struct packed {
        logic        applied;
        logic [31:0] score;
        logic [11:0] entry_echo;
    } t_res;

    typedef struct packed {
        logic        asym_enable;
        logic [15:0] fg_gain;
        logic [15:0] bg_gain;
    } t_cfg;

    // Classified work handed from front to back
    typedef enum logic [2:0] {
        OP_NULL,    // nothing to do, applied 0, score 0
        OP_ACC,     // counted posting
        OP_PEEK,    // stopped or out-of-range posting, report current score
        OP_READ,    // read and clear entry
        OP_ACK      // stop mark written, applied 1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [11:0] entry_echo;
        logic [15:0] weight;
        logic        foreground;
    } t_job;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CALC,
        BK_DONE
    } t_bk_state;

endpackage

>>> hw/rtl/hisa_front.sv
// ============================================================================
// hisa_front
// Accepts input beats, owns the stop-mark memory and its clearing pass,
// and classifies each beat into a job for the back end.
// ============================================================================
module hisa_front #(
    parameter int unsigned ENTRIES  = hisa_pkg::ENTRIES_DEF,
    parameter int unsigned CLUSTERS = hisa_pkg::CLUSTERS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hisa_pkg::t_cmd  i_item,
    input  logic            i_hold,
    output logic            o_push,
    output hisa_pkg::t_job  o_job,
    input  logic            i_full
);

    localparam int unsigned CW = $clog2(CLUSTERS);

    logic            r_stop_mem [CLUSTERS];
    logic            r_stop_rd;
    logic            r_clr_busy;
    logic [CW-1:0]   r_clr_cnt;
    logic            r_f_valid;
    hisa_pkg::t_cmd  r_f_item;

    logic            accept;
    logic [31:0]     in_cl_ext;
    logic [CW-1:0]   in_cl_idx;
    logic            in_cl_ok;
    logic            stop_we;
    logic [CW-1:0]   stop_wa;
    logic            stop_wd;
    logic            f_ent_ok;
    logic            f_cl_ok;

    assign o_stall   = r_clr_busy || i_hold || (r_f_valid && i_full);
    assign accept    = i_valid && !o_stall;
    assign in_cl_ext = 32'(i_item.word_id);
    assign in_cl_idx = in_cl_ext[CW-1:0];
    assign in_cl_ok  = in_cl_ext < 32'(CLUSTERS);

    // clearing sweep has the write port until done
    assign stop_we = r_clr_busy
                     || (accept && i_item.command == hisa_pkg::CMD_STOP && in_cl_ok);
    assign stop_wa = r_clr_busy ? r_clr_cnt : in_cl_idx;
    assign stop_wd = !r_clr_busy && i_item.stop_value;

    always_ff @(posedge i_clk) begin
        if (stop_we) begin
            r_stop_mem[stop_wa] <= stop_wd;
        end
        if (accept) begin
            r_stop_rd <= r_stop_mem[in_cl_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_cnt == CW'(CLUSTERS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (accept) begin
            r_f_valid <= 1'b1;
        end else if (o_push) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_item <= i_item;
        end
    end

    assign o_push   = r_f_valid && !i_full;
    assign f_ent_ok = 32'(r_f_item.entry_id) < 32'(ENTRIES);
    assign f_cl_ok  = 32'(r_f_item.word_id) < 32'(CLUSTERS);

    always_comb begin
        o_job.entry_echo = r_f_item.entry_id;
        o_job.foreground = r_f_item.foreground;
        o_job.weight     = (r_f_item.qry_weight < r_f_item.entry_weight)
                           ? r_f_item.qry_weight : r_f_item.entry_weight;
        unique case (r_f_item.command)
            hisa_pkg::CMD_ACC: begin
                if (!f_ent_ok) begin
                    o_job.op = hisa_pkg::OP_NULL;
                end else if (f_cl_ok && !r_stop_rd) begin
                    o_job.op = hisa_pkg::OP_ACC;
                end else begin
                    o_job.op = hisa_pkg::OP_PEEK;
                end
            end
            hisa_pkg::CMD_READ: begin
                o_job.op = f_ent_ok ? hisa_pkg::OP_READ : hisa_pkg::OP_NULL;
            end
            hisa_pkg::CMD_STOP: begin
                o_job.op = f_cl_ok ? hisa_pkg::OP_ACK : hisa_pkg::OP_NULL;
            end
            default: begin
                o_job.op = hisa_pkg::OP_NULL;
            end
        endcase
    end

endmodule

>>> hw/rtl/hisa_queue.sv
// ============================================================================
// hisa_queue
// Short job queue between the front and back ends.
// ============================================================================
module hisa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hisa_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output hisa_pkg::t_job  o_data,
    output logic            o_empty
);

    localparam int unsigned AW = $clog2(hisa_pkg::QDEPTH);
    localparam int unsigned NW = $clog2(hisa_pkg::QDEPTH + 1);

    hisa_pkg::t_job  r_slot [hisa_pkg::QDEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;

    assign o_full  = r_count == NW'(hisa_pkg::QDEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/hisa_back.sv
// ============================================================================
// hisa_back
// Executes jobs: score and hit-mark memories, gain scaling, saturating
// accumulate, read-and-clear, and the output register.
// ============================================================================
module hisa_back #(
    parameter int unsigned ENTRIES    = hisa_pkg::ENTRIES_DEF,
    parameter int unsigned SCORE_BITS = hisa_pkg::SCORE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hisa_pkg::t_cfg  i_cfg,
    input  logic            i_q_empty,
    input  hisa_pkg::t_job  i_q_data,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            o_valid,
    input  logic            i_stall,
    output hisa_pkg::t_res  o_res
);

    localparam int unsigned EW = $clog2(ENTRIES);
    localparam int unsigned AW = ((SCORE_BITS > hisa_pkg::INC_BITS)
                                  ? SCORE_BITS : hisa_pkg::INC_BITS) + 1;
    localparam int unsigned OW = (SCORE_BITS > hisa_pkg::OUT_BITS)
                                 ? SCORE_BITS : hisa_pkg::OUT_BITS;

    logic [SCORE_BITS-1:0]        r_score_mem [ENTRIES];
    logic                         r_hit_mem   [ENTRIES];
    logic [SCORE_BITS-1:0]        r_sc_rd;
    logic                         r_hit_rd;
    hisa_pkg::t_bk_state          r_state;
    hisa_pkg::t_bk_state          n_state;
    logic [EW-1:0]                r_clr_cnt;
    hisa_pkg::t_job               r_job;
    logic [SCORE_BITS-1:0]        r_cur;
    logic                         r_hit;
    logic [hisa_pkg::INC_BITS-1:0] r_inc;
    logic                         r_o_valid;
    hisa_pkg::t_res               r_o_res;

    logic                         out_free;
    logic                         done_fire;
    logic [31:0]                  q_ent_ext;
    logic [EW-1:0]                q_idx;
    logic [31:0]                  j_ent_ext;
    logic [EW-1:0]                j_idx;
    logic [15:0]                  gain;
    logic [hisa_pkg::PROD_BITS-1:0] prod;
    logic [AW-1:0]                sum;
    logic [SCORE_BITS-1:0]        new_score;
    logic                         sc_we;
    logic [SCORE_BITS-1:0]        sc_wd;
    logic                         hit_we;
    logic [EW-1:0]                hit_wa;
    logic                         hit_wd;
    hisa_pkg::t_res               res;

    function automatic logic [hisa_pkg::OUT_BITS-1:0] out_clip(
        input logic [SCORE_BITS-1:0] v
    );
        logic [OW-1:0] e;
        e = OW'(v);
        if ((e >> hisa_pkg::OUT_BITS) != '0) begin
            return '1;
        end
        return e[hisa_pkg::OUT_BITS-1:0];
    endfunction

    assign out_free  = !r_o_valid || !i_stall;
    assign q_ent_ext = 32'(i_q_data.entry_echo);
    assign q_idx     = q_ent_ext[EW-1:0];
    assign j_ent_ext = 32'(r_job.entry_echo);
    assign j_idx     = j_ent_ext[EW-1:0];

    // ---- state machine ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hisa_pkg::BK_CLEAR: begin
                if (r_clr_cnt == EW'(ENTRIES - 1)) begin
                    n_state = hisa_pkg::BK_IDLE;
                end
            end
            hisa_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = hisa_pkg::BK_CALC;
                end
            end
            hisa_pkg::BK_CALC: begin
                n_state = hisa_pkg::BK_DONE;
            end
            hisa_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = hisa_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = hisa_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        o_clearing = 1'b0;
        done_fire  = 1'b0;
        unique case (r_state)
            hisa_pkg::BK_CLEAR: o_clearing = 1'b1;
            hisa_pkg::BK_IDLE:  o_q_pop    = !i_q_empty;
            hisa_pkg::BK_DONE:  done_fire  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hisa_pkg::BK_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (o_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // ---- memories: read on pop, write when the job retires, hit marks also while clearing ----
    assign sc_we  = done_fire
                    && (r_job.op == hisa_pkg::OP_ACC || r_job.op == hisa_pkg::OP_READ);
    assign sc_wd  = (r_job.op == hisa_pkg::OP_ACC) ? new_score : '0;
    assign hit_we = o_clearing || sc_we;
    assign hit_wa = o_clearing ? r_clr_cnt : j_idx;
    assign hit_wd = !o_clearing && (r_job.op == hisa_pkg::OP_ACC);

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_score_mem[j_idx] <= sc_wd;
        end
        if (o_q_pop) begin
            r_sc_rd <= r_score_mem[q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit_we) begin
            r_hit_mem[hit_wa] <= hit_wd;
        end
        if (o_q_pop) begin
            r_hit_rd <= r_hit_mem[q_idx];
        end
    end

    // ---- datapath ----
    assign gain = r_job.foreground ? i_cfg.fg_gain : i_cfg.bg_gain;
    assign prod = hisa_pkg::PROD_BITS'(r_job.weight) * hisa_pkg::PROD_BITS'(gain)
                  + hisa_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_data;
        end
        if (r_state == hisa_pkg::BK_CALC) begin
            r_hit <= r_hit_rd;
            r_cur <= r_hit_rd ? r_sc_rd : '0;
            if (i_cfg.asym_enable) begin
                r_inc <= prod[hisa_pkg::GAIN_FRAC +: hisa_pkg::INC_BITS];
            end else begin
                r_inc <= hisa_pkg::INC_BITS'(r_job.weight);
            end
        end
    end

    assign sum       = AW'(r_cur) + AW'(r_inc);
    assign new_score = ((sum >> SCORE_BITS) != '0) ? '1 : sum[SCORE_BITS-1:0];

    always_comb begin
        res.entry_echo = r_job.entry_echo;
        unique case (r_job.op)
            hisa_pkg::OP_ACC: begin
                res.applied = 1'b1;
                res.score   = out_clip(new_score);
            end
            hisa_pkg::OP_PEEK: begin
                res.applied = 1'b0;
                res.score   = out_clip(r_cur);
            end
            hisa_pkg::OP_READ: begin
                res.applied = r_hit;
                res.score   = out_clip(r_cur);
            end
            hisa_pkg::OP_ACK: begin
                res.applied = 1'b1;
                res.score   = '0;
            end
            default: begin
                res.applied = 1'b0;
                res.score   = '0;
            end
        endcase
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (done_fire) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_o_res <= res;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o_res;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |-> !done_fire)
        else $error("result beat overwritten while stalled");

    a_acc_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_fire && r_job.op == hisa_pkg::OP_ACC) |=> (r_o_valid && r_o_res.applied))
        else $error("counted posting not reported as applied");

    a_acc_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_fire && r_job.op == hisa_pkg::OP_ACC) |-> (new_score >= r_cur))
        else $error("accumulated score went down");

    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hisa_pkg::BK_CLEAR) |-> (!r_o_valid && !o_q_pop))
        else $error("activity during hit-mark clearing");
`endif

endmodule

>>> hw/rtl/histogram_intersection_score_accumulator_core.sv
// ============================================================================
// histogram_intersection_score_accumulator_core
// Inverted-index scoring engine: stop-word filter, min-weight intersection,
// optional fg/bg gain, saturating per-entry score accumulate, read-and-clear.
// ============================================================================
//
//  channel | dir | handshake                    | beat
//  --------+-----+------------------------------+----------------------------
//  in      | in  | i_in_valid / o_in_stall      | t_cmd: command, ids, weights
//  out     | out | o_out_valid / i_out_stall    | t_res: applied, score, echo
//  cfg     | in  | i_cfg_wr_en (no wait)        | i_cfg_index, i_cfg_wdata
//
//  Front registers each beat with its stop-mark memory read, then classifies
//  it; back handles a job as score/hit read, gain multiply, add + write-back
//  and pops a new job only once the last has retired. An input beat reaches
//  the output via front register, job queue, back-end states, output register.
//  Rate is set by the back end's read-modify-write of the score memory.
//  After reset, o_in_stall stays high while stop and hit marks are swept
//  to zero; config writes are taken during that time. Reset is synchronous,
//  active low. The 4-deep job queue lets the front keep taking beats while
//  the output is stalled; the output register holds its beat until taken.
//
module histogram_intersection_score_accumulator_core #(
    parameter int unsigned ENTRIES    = hisa_pkg::ENTRIES_DEF,
    parameter int unsigned CLUSTERS   = hisa_pkg::CLUSTERS_DEF,
    parameter int unsigned SCORE_BITS = hisa_pkg::SCORE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input beats
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  hisa_pkg::t_cmd                       i_in_item,
    // result beats
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output hisa_pkg::t_res                       o_out_item,
    // config writes
    input  logic                                 i_cfg_wr_en,
    input  logic [hisa_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [hisa_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);

    hisa_pkg::t_cfg  r_cfg;

    logic            q_push;
    hisa_pkg::t_job  q_in;
    logic            q_full;
    logic            q_pop;
    hisa_pkg::t_job  q_out;
    logic            q_empty;
    logic            back_clearing;

    // Config registers; index 3 is a no-op
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.asym_enable <= 1'b0;
            r_cfg.fg_gain     <= hisa_pkg::GAIN_RESET;
            r_cfg.bg_gain     <= hisa_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                hisa_pkg::CFG_ASYM: r_cfg.asym_enable <= i_cfg_wdata[0];
                hisa_pkg::CFG_FG:   r_cfg.fg_gain     <= i_cfg_wdata;
                hisa_pkg::CFG_BG:   r_cfg.bg_gain     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: accept, stop-mark lookup/update, classify
    hisa_front #(
        .ENTRIES  (ENTRIES),
        .CLUSTERS (CLUSTERS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_hold  (back_clearing),
        .o_push  (q_push),
        .o_job   (q_in),
        .i_full  (q_full)
    );

    // Decoupling queue
    hisa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Back: score read-modify-write and result beat
    hisa_back #(
        .ENTRIES    (ENTRIES),
        .SCORE_BITS (SCORE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_clearing (back_clearing),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_res      (o_out_item)
    );

endmodule
